>>> sv/chd_pkg.sv
// ----------------------------------------------------------------------------
// chd_pkg
// Shared types, codes and helpers for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package chd_pkg;

  // Default width of the chunk size accumulator and byte counter.
  localparam int unsigned SIZE_WIDTH = 32;

  // One hex digit carries log2(16) bits.
  localparam int unsigned HEX_DIGIT_BITS = 4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    ST_BYTE = 2'd0,
    ST_DONE = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_SIZE  = 4'b0001,
    PH_DATA  = 4'b0010,
    PH_TRAIL = 4'b0100,
    PH_HALT  = 4'b1000
  } phase_e;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic                      is_hex;
    logic [HEX_DIGIT_BITS-1:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h = '0;
    case (c) inside
      [8'h30:8'h39]: begin
        h.is_hex = 1'b1;
        h.value  = c[3:0];
      end
      [8'h41:8'h46], [8'h61:8'h66]: begin
        h.is_hex = 1'b1;
        h.value  = 4'(c[3:0] + 4'd9);
      end
      default: h = '0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

>>> sv/chd_if.sv
// ----------------------------------------------------------------------------
// chd_in_if / chd_out_if
// Valid/ready stream interfaces for body bytes and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface chd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] body_byte;

  modport source (output valid, output body_byte, input ready);
  modport sink   (input valid, input body_byte, output ready);
  modport monitor (input valid, input body_byte, input ready);
endinterface

interface chd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;

  modport source (output valid, output out_byte, output status, input ready);
  modport sink   (input valid, input out_byte, input status, output ready);
  modport monitor (input valid, input out_byte, input status, input ready);
endinterface

`default_nettype wire

>>> sv/chd_in_stage.sv
// ----------------------------------------------------------------------------
// chd_in_stage
// Input register: holds one body byte until the parser consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_in_stage (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  chd_in_if.sink     body_i,
  input  wire logic  advance_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       take;

  assign body_i.ready = !valid_q || advance_i;
  assign take         = body_i.valid && body_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= body_i.body_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

>>> sv/chd_parser.sv
// ----------------------------------------------------------------------------
// chd_parser
// Chunk framing state and the per-byte step; result is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_parser #(
  parameter int unsigned SizeWidth = chd_pkg::SIZE_WIDTH
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  output chd_pkg::result_t result_o
);

  localparam int unsigned DigitBits = chd_pkg::HEX_DIGIT_BITS;

  chd_pkg::phase_e      phase_q, phase_d;
  logic [SizeWidth-1:0] acc_q, acc_d;
  logic                 stopped_q, stopped_d;
  logic                 cr_q, cr_d;
  logic [SizeWidth-1:0] rem_q, rem_d;
  logic                 skip_q, skip_d;
  chd_pkg::hex_t        hex;

  assign hex = chd_pkg::hex_decode(byte_i);

  always_comb begin
    phase_d   = phase_q;
    acc_d     = acc_q;
    stopped_d = stopped_q;
    cr_d      = cr_q;
    rem_d     = rem_q;
    skip_d    = skip_q;
    result_o  = '0;

    unique case (phase_q)
      chd_pkg::PH_SIZE: begin
        if (cr_q && (byte_i == chd_pkg::CHAR_LF)) begin
          acc_d     = '0;
          stopped_d = 1'b0;
          cr_d      = 1'b0;
          if (acc_q == '0) begin
            phase_d         = chd_pkg::PH_HALT;
            result_o.valid  = 1'b1;
            result_o.status = chd_pkg::ST_DONE;
          end else begin
            rem_d   = acc_q;
            phase_d = chd_pkg::PH_DATA;
          end
        end else if (byte_i == chd_pkg::CHAR_CR) begin
          cr_d      = 1'b1;
          stopped_d = 1'b1;
        end else begin
          cr_d = 1'b0;
          if (!hex.is_hex) begin
            stopped_d = 1'b1;
          end else if (!stopped_q) begin
            // top digit must be clear before shifting in another one
            if (acc_q[SizeWidth-1 -: DigitBits] != '0) begin
              phase_d         = chd_pkg::PH_HALT;
              result_o.valid  = 1'b1;
              result_o.status = chd_pkg::ST_OVF;
            end else begin
              acc_d = {acc_q[SizeWidth-DigitBits-1:0], hex.value};
            end
          end
        end
      end
      chd_pkg::PH_DATA: begin
        rem_d = rem_q - SizeWidth'(1);
        if (rem_d == '0) begin
          phase_d = chd_pkg::PH_TRAIL;
          skip_d  = 1'b0;
        end
        result_o.valid    = 1'b1;
        result_o.out_byte = byte_i;
        result_o.status   = chd_pkg::ST_BYTE;
      end
      chd_pkg::PH_TRAIL: begin
        if (!skip_q) begin
          skip_d = 1'b1;
        end else begin
          skip_d    = 1'b0;
          phase_d   = chd_pkg::PH_SIZE;
          acc_d     = '0;
          stopped_d = 1'b0;
          cr_d      = 1'b0;
        end
      end
      chd_pkg::PH_HALT: begin
        phase_d = chd_pkg::PH_HALT;
      end
      default: begin
        phase_d = chd_pkg::PH_HALT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= chd_pkg::PH_SIZE;
      acc_q     <= '0;
      stopped_q <= 1'b0;
      cr_q      <= 1'b0;
      rem_q     <= '0;
      skip_q    <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      acc_q     <= acc_d;
      stopped_q <= stopped_d;
      cr_q      <= cr_d;
      rem_q     <= rem_d;
      skip_q    <= skip_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/chd_out_stage.sv
// ----------------------------------------------------------------------------
// chd_out_stage
// Result register driving the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire chd_pkg::result_t result_i,
  chd_out_if.source             result_o,
  output logic                  free_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic [1:0] status_q;

  assign free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = result_i.valid;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && result_i.valid) begin
      byte_q   <= result_i.out_byte;
      status_q <= result_i.status;
    end
  end

  assign result_o.valid    = valid_q;
  assign result_o.out_byte = byte_q;
  assign result_o.status   = status_q;

endmodule

`default_nettype wire

>>> sv/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Deframes an HTTP chunked transfer body into its payload bytes.
// ----------------------------------------------------------------------------
// One body byte per cycle goes in while the output is not stalled; each byte
// passes through two registers (input register, then result register), and
// its result is registered as the byte leaves the input register, so the
// sustained rate is one byte per cycle. The chunk state machine updates in the same
// cycle a byte leaves the input register, which is what fixes that rate.
// Size lines are read up to CR LF; leading hex digits form the chunk size,
// anything after the first non-hex byte on the line is ignored. Data bytes
// come out with status 0, a zero size gives one status 1 item and an
// oversized chunk size gives one status 2 item; after either, all input is
// swallowed until reset. Size-line bytes and the two bytes after each chunk
// produce no item. Out_byte is zero on status items.
// ----------------------------------------------------------------------------
`default_nettype none

module http_chunked_body_decoder #(
  parameter int unsigned SizeWidth = chd_pkg::SIZE_WIDTH
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  chd_in_if.sink    body_i,
  chd_out_if.source result_o
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             out_free;
  logic             advance;   // byte leaves input register into the parser
  chd_pkg::result_t step_res;

  assign advance = s1_valid && out_free;

  chd_in_stage u_in (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .body_i    (body_i),
    .advance_i (advance),
    .valid_o   (s1_valid),
    .byte_o    (s1_byte)
  );

  chd_parser #(
    .SizeWidth (SizeWidth)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .byte_i   (s1_byte),
    .result_o (step_res)
  );

  // Loads on every advance; a byte with no result simply leaves it empty.
  chd_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .result_i (step_res),
    .result_o (result_o),
    .free_o   (out_free)
  );

endmodule

`default_nettype wire

>>> sv/chd_checker.sv
// ----------------------------------------------------------------------------
// chd_checker
// Port-level assertions for the chunked body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module chd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic [1:0] status_i
);

  logic halted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
    end else if (valid_i && ready_i && (status_i != chd_pkg::ST_BYTE)) begin
      halted_q <= 1'b1;
    end
  end

  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=>
      valid_i && $stable(out_byte_i) && $stable(status_i))
    else $error("stalled result changed");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (status_i == chd_pkg::ST_BYTE) ||
                (status_i == chd_pkg::ST_DONE) ||
                (status_i == chd_pkg::ST_OVF))
    else $error("bad status code");

  a_status_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && (status_i != chd_pkg::ST_BYTE) |-> out_byte_i == 8'd0)
    else $error("status item carries nonzero byte");

  a_quiet_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !valid_i)
    else $error("result after end of body");

endmodule

bind http_chunked_body_decoder chd_checker u_chd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .valid_i    (result_o.valid),
  .ready_i    (result_o.ready),
  .out_byte_i (result_o.out_byte),
  .status_i   (result_o.status)
);

`default_nettype wire

>>> verif/tb_http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// tb_http_chunked_body_decoder
// Self-checking bench for the chunked body decoder: streams one long chunked
// body (directed chunks, then random chunks with extensions, stray CRs and
// bad trailers), predicts every payload and status item in a scoreboard,
// and finishes on a zero size, an empty size line or a size overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_http_chunked_body_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import chd_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_BYTES  = 500;
  localparam int IDLE_PCT      = 13;
  // Two register stages inside the block; the extra settle time catches strays.
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [7:0] out_byte;
    status_e    status;
  } decoded_item_t;

  typedef enum int {END_ZERO_SIZE, END_EMPTY_LINE, END_OVERFLOW} body_end_e;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the chunk framing state, keeps the items the decoder
  // owes, and checks each item that leaves the block.
  // --------------------------------------------------------------------------
  class chunk_scoreboard;
    phase_e               phase;
    logic [SIZE_WIDTH-1:0] size_acc;
    bit                   digits_done;
    bit                   cr_seen;
    logic [SIZE_WIDTH-1:0] remaining;
    bit                   trail_skipped;
    decoded_item_t        expected_items[$];
    int                   errors;
    int                   items_checked;

    function new();
      phase         = PH_SIZE;
      remaining     = '0;
      trail_skipped = 1'b0;
      errors        = 0;
      items_checked = 0;
      clear_line();
    endfunction

    function void clear_line();
      size_acc    = '0;
      digits_done = 1'b0;
      cr_seen     = 1'b0;
    endfunction

    static function bit hex_digit(input logic [7:0] c, output logic [3:0] v);
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
        v = 4'(c - "0");
        return 1'b1;
      end
      if (c >= "a" && c <= "f") begin
        v = 4'(c - "a" + 10);
        return 1'b1;
      end
      if (c >= "A" && c <= "F") begin
        v = 4'(c - "A" + 10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    // Advance the framing state by one body byte; hit says an item is owed.
    function void deframe_byte(input logic [7:0] b, output bit hit,
                               output decoded_item_t item);
      logic [3:0] digit;
      hit           = 1'b0;
      item.out_byte = 8'h00;
      item.status   = ST_BYTE;
      case (phase)
        PH_SIZE: begin
          if (cr_seen && b == CHAR_LF) begin
            if (size_acc == '0) begin
              phase       = PH_HALT;
              hit         = 1'b1;
              item.status = ST_DONE;
            end else begin
              remaining = size_acc;
              phase     = PH_DATA;
            end
            clear_line();
          end else if (b == CHAR_CR) begin
            cr_seen     = 1'b1;
            digits_done = 1'b1;
          end else begin
            cr_seen = 1'b0;
            if (!hex_digit(b, digit)) begin
              digits_done = 1'b1;
            end else if (!digits_done) begin
              if (size_acc[SIZE_WIDTH-1 -: HEX_DIGIT_BITS] != '0) begin
                phase       = PH_HALT;
                hit         = 1'b1;
                item.status = ST_OVF;
              end else begin
                size_acc = {size_acc[SIZE_WIDTH-HEX_DIGIT_BITS-1:0], digit};
              end
            end
          end
        end
        PH_DATA: begin
          remaining = remaining - 1'b1;
          if (remaining == '0) begin
            phase         = PH_TRAIL;
            trail_skipped = 1'b0;
          end
          hit           = 1'b1;
          item.out_byte = b;
        end
        PH_TRAIL: begin
          if (!trail_skipped) begin
            trail_skipped = 1'b1;
          end else begin
            trail_skipped = 1'b0;
            phase         = PH_SIZE;
            clear_line();
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(input logic [7:0] b);
      bit            hit;
      decoded_item_t item;
      deframe_byte(b, hit, item);
      if (hit) expected_items = {expected_items, item};
    endfunction

    function void check_item(input logic [7:0] out_byte, input logic [1:0] status);
      decoded_item_t want;
      if (expected_items.size() == 0) begin
        $error("unexpected item: out_byte %02h status %0d", out_byte, status);
        errors++;
        return;
      end
      want = expected_items.pop_front();
      items_checked++;
      if (status !== want.status) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, status);
        errors++;
      end
      if (out_byte !== want.out_byte) begin
        $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, out_byte);
        errors++;
      end
    endfunction

    function int pending();
      return expected_items.size();
    endfunction

    function void check_drained();
      if (expected_items.size() != 0) begin
        $error("%0d expected items never arrived", expected_items.size());
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;
  bit   steady;       // no idling on either side while set
  int   bytes_sent;
  int   chunks_sent;

  chd_in_if  body_if ();
  chd_out_if result_if ();

  chunk_scoreboard sb = new();

  http_chunked_body_decoder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .body_i   (body_if),
    .result_o (result_if)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Receiver: ready changes on the falling edge, stalls about 13% of cycles while steady is clear.
  always @(negedge clk_i) begin
    result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Output monitor: values read at the rising edge are the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      sb.check_item(result_if.out_byte, result_if.status);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends just after a falling edge.
  // --------------------------------------------------------------------------

  // Present one byte, with random idle cycles in front, and hold it until
  // the block takes it. Valid stays high across back-to-back items.
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      body_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    body_if.valid     <= 1'b1;
    body_if.body_byte <= b;
    @(posedge clk_i);
    while (!body_if.ready) @(posedge clk_i);
    sb.note_byte(b);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender off until the block has delivered everything owed.
  task automatic pause_until_drained();
    body_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'("0" + nib);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + nib - 10);
  endfunction

  function automatic bit is_hex_char(input logic [7:0] c);
    logic [3:0] v;
    return chunk_scoreboard::hex_digit(c, v);
  endfunction

  // Any byte that stops the digits without starting a line end.
  function automatic logic [7:0] stop_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_hex_char(c) || c == CHAR_CR);
    return c;
  endfunction

  // Size line: optional leading zeros, hex digits in mixed case, then,
  // when messy, an extension and/or a CR that is not followed by LF.
  task automatic send_size_line(input int unsigned size, input bit messy);
    int         nd;
    int         lead;
    int         kind;
    logic [7:0] c;
    nd = 1;
    while (nd < 8 && (size >> (4 * nd)) != 0) nd++;
    lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (lead) send_byte("0");
    for (int i = nd - 1; i >= 0; i--) send_byte(hex_char(4'(size >> (4 * i))));
    if (messy) begin
      kind = $urandom_range(0, 2);
      if (kind != 1) begin
        send_byte(stop_byte());
        repeat ($urandom_range(0, 4)) begin
          do c = 8'($urandom_range(0, 255)); while (c == CHAR_CR);
          send_byte(c);
        end
      end
      if (kind != 0) begin
        send_byte(CHAR_CR);
        do c = 8'($urandom_range(0, 255)); while (c == CHAR_LF);
        send_byte(c);
      end
    end
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
  endtask

  task automatic send_chunk(input int unsigned size, input bit messy, input bit bad_trailer);
    send_size_line(size, messy);
    repeat (size) send_byte(8'($urandom_range(0, 255)));
    if (bad_trailer) begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
    chunks_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0]  directed_q[$];
    int          steady_from;
    int          pause_at;
    int unsigned size;
    body_end_e   ending;

    clk_i             = 1'b0;
    rst_ni            = 1'b0;
    steady            = 1'b0;
    bytes_sent        = 0;
    chunks_sent       = 0;
    body_if.valid     = 1'b0;
    body_if.body_byte = 8'h00;
    result_if.ready   = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed chunks:
    //  - long run of leading zeros before the digit, payload 00, trailer of
    //    FF 00 that is dropped unchecked
    //  - extension after the size, a CR followed by a non-LF byte, payload
    //    FF and CR
    directed_q = '{"0", "0", "0", "0", "0", "0", "0", "0", "0", "0", "1",
                   CHAR_CR, CHAR_LF, 8'h00, 8'hFF, 8'h00,
                   "2", ";", CHAR_CR, "Z", CHAR_CR, CHAR_LF, 8'hFF, CHAR_CR,
                   CHAR_CR, CHAR_LF};
    foreach (directed_q[i]) send_byte(directed_q[i]);
    chunks_sent += 2;

    pause_until_drained();

    // Random chunks: mostly well formed with small sizes, some with
    // extensions or stray CRs, some with garbage trailers, a few larger.
    steady_from = $urandom_range(4, 8);
    pause_at    = $urandom_range(20, 24);
    while (bytes_sent < RANDOM_BYTES) begin
      steady = (chunks_sent >= steady_from) && (chunks_sent < steady_from + 15);
      if (chunks_sent == pause_at) pause_until_drained();
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
      send_chunk(size, $urandom_range(0, 99) < 20, $urandom_range(0, 99) < 15);
    end
    steady = 1'b0;

    // Close the body one of three ways; the block halts after any of them.
    ending = body_end_e'($urandom_range(0, 2));
    case (ending)
      END_ZERO_SIZE: begin
        send_size_line(0, $urandom_range(0, 1));
      end
      END_EMPTY_LINE: begin
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
      default: begin
        // Nonzero lead digit plus eight more overflows a 32-bit size.
        send_byte(hex_char(4'($urandom_range(1, 15))));
        repeat ($urandom_range(8, 10)) send_byte(hex_char(4'($urandom_range(0, 15))));
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
      end
    endcase

    // Everything after the halt must be swallowed.
    repeat ($urandom_range(20, 40)) send_byte(8'($urandom_range(0, 255)));
    body_if.valid <= 1'b0;

    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    sb.check_drained();

    $display("Coverage: %0d body bytes over %0d chunks, %0d decoded items checked",
             bytes_sent, chunks_sent, sb.items_checked);
    $display("Body closed by %s, followed by ignored bytes", ending.name());
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished within the time limit.
  initial begin
    #1_000_000;
    $display("Timeout: decoder stopped making progress");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
